>>> sv/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_EXPIRE = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] delay_ticks;
    logic [7:0]  action_id;
    logic [15:0] timer_remaining;
    logic        run_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fire_valid;
    logic [7:0]  fire_action;
    logic [15:0] head_wait;
    logic        timer_enable;
    logic [4:0]  entry_count;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/delta_timer_queue_unit.sv
`default_nettype none

// Delta-sorted queue of pending timed actions.
//
// Command channel: an item is taken at a rising edge with start high and busy
// low. Commands: insert (walk and splice, dropped if the pool is full), expire
// (pop the head and fire it), cancel (unlink the first match by id, fold its
// wait into the successor, optionally fire the id right away).
// Result channel: done_o is high for exactly one cycle with result_o; the
// receiver cannot stall, so nothing is held back. busy stays high from the
// item's acceptance until the cycle in which its result shows.
//
// Sequence: every list access goes through a single cell memory with one
// registered read port and one write port. A walk visits 1 up to POOL_DEPTH
// entries. Insert walks the list from the head, writes the new cell, trims
// the wait of the entry after it and links the entry before it; expire reads
// and pops the head; cancel walks the list and, when the removed entry has a
// successor, folds its wait into it. Insert into an empty list, a dropped
// insert, a command on an empty list and the unused command skip these steps.
// Each command closes with a read of the new head's wait for the timer preset.
// One item at a time: the next one can be taken in the cycle in which the previous result shows.
//
// Reset: list empty, all cells free. Cell contents are not cleared; a cell
// is fully written when allocated, so no clearing pass is needed.
module delta_timer_queue_unit #(
  parameter int unsigned POOL_DEPTH = dtq_pkg::POOL_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire dtq_pkg::in_item_t item_i,
  output logic                  busy,
  output logic                  done_o,
  output dtq_pkg::out_item_t    result_o
);
  import dtq_pkg::*;

  localparam int unsigned IW = $clog2(POOL_DEPTH);     // cell address
  localparam int unsigned LW = IW + 1;                 // link, holds the null marker
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1); // pending count
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(POOL_DEPTH);

  typedef struct packed {
    logic [7:0]    action;
    logic [15:0]   ticks;
    logic [LW-1:0] link;
  } cell_t;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_INS_WALK  = 10'b00_0000_0010,
    S_INS_FRESH = 10'b00_0000_0100,
    S_INS_CUR   = 10'b00_0000_1000,
    S_INS_PREV  = 10'b00_0001_0000,
    S_EXP       = 10'b00_0010_0000,
    S_CAN_WALK  = 10'b00_0100_0000,
    S_CAN_SUM   = 10'b00_1000_0000,
    S_HW_RD     = 10'b01_0000_0000,
    S_HW_OUT    = 10'b10_0000_0000
  } state_e;

  // Cell memory: one write port with field enables, one registered read port.
  cell_t           mem [POOL_DEPTH];
  cell_t           rd_q;
  logic            re;
  logic [IW-1:0]   ra;
  logic            we_full, we_ticks, we_link;
  logic [IW-1:0]   wa;
  cell_t           wd;

  always_ff @(posedge clk_i) begin
    if (we_full) begin
      mem[wa] <= wd;
    end else begin
      if (we_ticks) mem[wa].ticks <= wd.ticks;
      if (we_link)  mem[wa].link  <= wd.link;
    end
    if (re) rd_q <= mem[ra];
  end

  state_e             state_q, state_d;
  in_item_t           cmd_q, cmd_d;
  logic [LW-1:0]      cur_q, cur_d, prev_q, prev_d, head_q, head_d;
  logic [IW-1:0]      fresh_q, fresh_d;
  logic [15:0]        rem_q, rem_d, cur_ticks_q, cur_ticks_d;
  logic [CW-1:0]      count_q, count_d;
  logic [POOL_DEPTH-1:0] used_q, used_d;
  status_e            status_q, status_d;
  logic               fire_q, fire_d;
  logic [7:0]         act_q, act_d;
  out_item_t          res_q, res_d;
  logic               done_q, done_d;

  // Lowest free cell.
  logic          free_ok;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // Head wait was overwritten with the live timer at insert start; forward it.
  logic [15:0] walk_ticks;
  logic [16:0] fold_sum;
  logic [15:0] fold_sat;
  logic        rd_link_null;
  assign walk_ticks   = (cur_q == head_q) ? cmd_q.timer_remaining : rd_q.ticks;
  assign fold_sum     = {1'b0, rd_q.ticks} + {1'b0, cur_ticks_q};
  assign fold_sat     = fold_sum[16] ? 16'hFFFF : fold_sum[15:0];
  assign rd_link_null = (rd_q.link >= NULL_LINK);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    head_d      = head_q;
    fresh_d     = fresh_q;
    rem_d       = rem_q;
    cur_ticks_d = cur_ticks_q;
    count_d     = count_q;
    used_d      = used_q;
    status_d    = status_q;
    fire_d      = fire_q;
    act_d       = act_q;
    res_d       = res_q;
    done_d      = 1'b0;
    re          = 1'b0;
    ra          = head_q[IW-1:0];
    we_full     = 1'b0;
    we_ticks    = 1'b0;
    we_link     = 1'b0;
    wa          = '0;
    wd          = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = item_i;
          status_d = ST_OK;
          fire_d   = 1'b0;
          act_d    = '0;
          prev_d   = NULL_LINK;
          cur_d    = head_q;
          state_d  = S_HW_RD;
          case (item_i.command)
            CMD_INSERT: begin
              if (count_q >= FULL_CNT || !free_ok) begin
                status_d = ST_FULL;
              end else if (count_q == '0) begin
                we_full          = 1'b1;
                wa               = free_idx;
                wd.action        = item_i.action_id;
                wd.ticks         = item_i.delay_ticks;
                wd.link          = NULL_LINK;
                used_d[free_idx] = 1'b1;
                head_d           = {1'b0, free_idx};
                count_d          = CW'(1);
              end else begin
                we_ticks         = 1'b1;
                wa               = head_q[IW-1:0];
                wd.ticks         = item_i.timer_remaining;
                re               = 1'b1;
                used_d[free_idx] = 1'b1;
                fresh_d          = free_idx;
                rem_d            = item_i.delay_ticks;
                state_d          = S_INS_WALK;
              end
            end
            CMD_EXPIRE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                re      = 1'b1;
                state_d = S_EXP;
              end
            end
            CMD_CANCEL: begin
              if (item_i.run_now) begin
                fire_d = 1'b1;
                act_d  = item_i.action_id;
              end
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                re      = 1'b1;
                state_d = S_CAN_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_WALK: begin
        if (rem_q > walk_ticks) begin
          rem_d  = rem_q - walk_ticks;
          prev_d = cur_q;
          if (rd_link_null) begin
            cur_d   = NULL_LINK;
            state_d = S_INS_FRESH;
          end else begin
            cur_d = rd_q.link;
            re    = 1'b1;
            ra    = rd_q.link[IW-1:0];
          end
        end else begin
          cur_ticks_d = walk_ticks - rem_q;
          state_d     = S_INS_FRESH;
        end
      end

      S_INS_FRESH: begin
        we_full   = 1'b1;
        wa        = fresh_q;
        wd.action = cmd_q.action_id;
        wd.ticks  = rem_q;
        wd.link   = cur_q;
        if (cur_q == head_q) head_d = {1'b0, fresh_q};
        count_d   = count_q + CW'(1);
        state_d   = S_INS_CUR;
      end

      S_INS_CUR: begin
        if (cur_q != NULL_LINK) begin
          we_ticks = 1'b1;
          wa       = cur_q[IW-1:0];
          wd.ticks = cur_ticks_q;
        end
        state_d = S_INS_PREV;
      end

      S_INS_PREV: begin
        if (prev_q != NULL_LINK) begin
          we_link = 1'b1;
          wa      = prev_q[IW-1:0];
          wd.link = {1'b0, fresh_q};
        end
        state_d = S_HW_RD;
      end

      S_EXP: begin
        fire_d                  = 1'b1;
        act_d                   = rd_q.action;
        used_d[head_q[IW-1:0]]  = 1'b0;
        count_d                 = count_q - CW'(1);
        head_d                  = (rd_link_null || count_q == CW'(1)) ? NULL_LINK
                                                                       : rd_q.link;
        if (rd_link_null) count_d = '0;
        state_d                 = S_HW_RD;
      end

      S_CAN_WALK: begin
        if (rd_q.action == cmd_q.action_id) begin
          if (prev_q != NULL_LINK) begin
            we_link = 1'b1;
            wa      = prev_q[IW-1:0];
            wd.link = rd_link_null ? NULL_LINK : rd_q.link;
          end else begin
            head_d = rd_link_null ? NULL_LINK : rd_q.link;
          end
          used_d[cur_q[IW-1:0]] = 1'b0;
          count_d               = count_q - CW'(1);
          cur_ticks_d           = rd_q.ticks;
          if (rd_link_null) begin
            state_d = S_HW_RD;
          end else begin
            re      = 1'b1;
            ra      = rd_q.link[IW-1:0];
            cur_d   = rd_q.link;
            state_d = S_CAN_SUM;
          end
        end else if (rd_link_null) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_HW_RD;
        end else begin
          prev_d = cur_q;
          cur_d  = rd_q.link;
          re     = 1'b1;
          ra     = rd_q.link[IW-1:0];
        end
      end

      S_CAN_SUM: begin
        we_ticks = 1'b1;
        wa       = cur_q[IW-1:0];
        wd.ticks = fold_sat;
        state_d  = S_HW_RD;
      end

      S_HW_RD: begin
        if (count_q == '0) head_d = NULL_LINK;
        re      = (count_q != '0);
        state_d = S_HW_OUT;
      end

      S_HW_OUT: begin
        res_d.status       = status_q;
        res_d.fire_valid   = fire_q;
        res_d.fire_action  = act_q;
        res_d.head_wait    = (count_q != '0) ? rd_q.ticks : 16'd0;
        res_d.timer_enable = (count_q != '0);
        res_d.entry_count  = 5'(count_q);
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= NULL_LINK;
      count_q  <= '0;
      used_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      fire_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      used_q   <= used_d;
      done_q   <= done_d;
      status_q <= status_d;
      fire_q   <= fire_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    fresh_q     <= fresh_d;
    rem_q       <= rem_d;
    cur_ticks_q <= cur_ticks_d;
    act_q       <= act_d;
    res_q       <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // A result only shows once the sequencer is back at rest.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // Pending count never exceeds the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("pending count above pool depth");

  // At rest, the empty list and the null head go together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ((count_q == '0) == (head_q == NULL_LINK)))
    else $error("head and count disagree");

  // At rest, allocated cells match the pending count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> ($countones(used_q) == int'(count_q)))
    else $error("cell allocation out of step with count");

endmodule

`default_nettype wire
